>>> rtl/scp_pkg.sv
// Package: constants, codes and helpers shared by the script chunk parser files
`default_nettype none
package scp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int PADDR_WIDTH = 3;
	localparam logic REG_CHUNK_LIMIT = 1'b0;
	localparam logic [15:0] CHUNK_LIMIT_RESET = 16'd64;

	localparam logic [7:0] OP_0 = 8'h00;
	localparam logic [7:0] OP_LEN8 = 8'h4c;
	localparam logic [7:0] OP_LEN16 = 8'h4d;
	localparam logic [7:0] OP_LEN32 = 8'h4e;

	typedef enum logic [2:0] {
		ROLE_PLAIN = 3'd0,
		ROLE_DIRECT = 3'd1,
		ROLE_EXTENDED = 3'd2,
		ROLE_LENGTH = 3'd3,
		ROLE_PAYLOAD = 3'd4,
		ROLE_IGNORED = 3'd5
	} role_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_TRUNCATED = 2'd1,
		ST_TOO_MANY = 2'd2
	} status_t;

	function automatic logic [2:0] length_field_size(input logic [7:0] op);
		logic [2:0] size;
		if (op == OP_LEN8) begin
			size = 3'd1;
		end else if (op == OP_LEN16) begin
			size = 3'd2;
		end else begin
			size = 3'd4;
		end
		return size;
	endfunction

endpackage
`default_nettype wire

>>> rtl/scp_ifs.sv
// Interfaces: script byte input channel and chunk result output channel
`default_nettype none
interface scp_in_if;
	logic valid;
	logic ready;
	logic [7:0] script_byte;
	logic last_byte;

	modport source (output valid, output script_byte, output last_byte, input ready);
	modport sink (input valid, input script_byte, input last_byte, output ready);
endinterface

interface scp_out_if;
	logic valid;
	logic ready;
	logic [2:0] byte_role;
	logic [7:0] chunk_opcode;
	logic [7:0] data_byte;
	logic [31:0] payload_length;
	logic chunk_done;
	logic [15:0] chunk_count;
	logic script_done;
	logic [1:0] status;

	modport source (output valid, output byte_role, output chunk_opcode, output data_byte,
		output payload_length, output chunk_done, output chunk_count, output script_done,
		output status, input ready);
	modport sink (input valid, input byte_role, input chunk_opcode, input data_byte,
		input payload_length, input chunk_done, input chunk_count, input script_done,
		input status, output ready);
endinterface
`default_nettype wire

>>> rtl/script_chunk_parser.sv
// Top level: script chunk parser with APB-style configuration port
//
// Usage:
//   in_ch carries one script byte per transaction, last_byte marks the final byte.
//   out_ch returns exactly one result per input byte, in order: the byte's role,
//   the chunk opcode, payload byte, declared length, chunk completion, running
//   chunk count, end of script and status.
//   The APB port holds the chunk limit at byte address 0 (reset value 64); write it
//   only while no script byte is in flight.
// Timing:
//   The result of a byte is registered when the byte is accepted and is valid
//   after that edge. Throughput is one byte per cycle while out_ch is not stalled;
//   the parse state is a single register stage updated at acceptance.
// Reset:
//   arst_n clears the parse state, the output valid and restores the chunk limit.
//   After the final byte of a script the parse state returns to its reset value.
// Stall:
//   While out_ch is stalled the result register holds and in_ch.ready drops;
//   a new byte is taken in the same cycle the pending result leaves.
`default_nettype none
module script_chunk_parser
	import scp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	scp_in_if.sink in_ch,
	scp_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_WIDTH-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	logic [15:0] chunk_limit_q;

	phase_t phase_q, phase_d;
	logic [7:0] opcode_q, opcode_d;
	logic [2:0] len_left_q, len_left_d;
	logic [31:0] len_accum_q, len_accum_d;
	logic [31:0] pay_left_q, pay_left_d;
	logic [COUNT_WIDTH-1:0] chunks_q, chunks_d;
	status_t error_q, error_d;

	logic out_valid_q;
	role_t role_q, role_d;
	logic [7:0] op_q, op_d;
	logic [7:0] data_q, data_d;
	logic [31:0] plen_q, plen_d;
	logic done_q, done_d;
	logic [15:0] count_q;
	logic last_q;
	status_t status_q;

	logic accept;
	logic [2:0] total;
	logic [2:0] left_eff;
	logic [1:0] byte_pos;
	logic [31:0] accum_new;
	logic at_limit;
	logic finish;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_WIDTH-1] == REG_CHUNK_LIMIT) ? {16'd0, chunk_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q <= CHUNK_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[PADDR_WIDTH-1] == REG_CHUNK_LIMIT) begin
			chunk_limit_q <= pwdata[15:0];
		end
	end

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;

	assign total = length_field_size(opcode_q);
	assign left_eff = (len_left_q == 3'd0 || len_left_q > total) ? total : len_left_q;
	assign byte_pos = 2'(total - left_eff);
	assign at_limit = (CMP_WIDTH'(chunks_q) >= CMP_WIDTH'(chunk_limit_q)) ||
		(chunks_q == COUNT_MAX);

	always_comb begin
		case (byte_pos)
			2'd0: accum_new = len_accum_q | {24'd0, in_ch.script_byte};
			2'd1: accum_new = len_accum_q | {16'd0, in_ch.script_byte, 8'd0};
			2'd2: accum_new = len_accum_q | {8'd0, in_ch.script_byte, 16'd0};
			default: accum_new = len_accum_q | {in_ch.script_byte, 24'd0};
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		opcode_d = opcode_q;
		len_left_d = len_left_q;
		len_accum_d = len_accum_q;
		pay_left_d = pay_left_q;
		chunks_d = chunks_q;
		error_d = error_q;
		role_d = ROLE_IGNORED;
		op_d = 8'd0;
		data_d = 8'd0;
		plen_d = 32'd0;
		done_d = 1'b0;
		finish = 1'b0;

		if (error_q == ST_OK) begin
			case (phase_q)
				PH_LENGTH: begin
					role_d = ROLE_LENGTH;
					op_d = opcode_q;
					len_accum_d = accum_new;
					len_left_d = left_eff - 3'd1;
					plen_d = accum_new;
					if (left_eff == 3'd1) begin
						if (accum_new == 32'd0) begin
							finish = 1'b1;
						end else begin
							pay_left_d = accum_new;
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					role_d = ROLE_PAYLOAD;
					op_d = opcode_q;
					data_d = in_ch.script_byte;
					plen_d = len_accum_q;
					if (pay_left_q != 32'd0) begin
						pay_left_d = pay_left_q - 32'd1;
					end
					if (pay_left_q <= 32'd1) begin
						finish = 1'b1;
					end
				end
				default: begin
					opcode_d = in_ch.script_byte;
					op_d = in_ch.script_byte;
					if (in_ch.script_byte == OP_0 || in_ch.script_byte > OP_LEN32) begin
						role_d = ROLE_PLAIN;
						len_accum_d = 32'd0;
						finish = 1'b1;
					end else if (in_ch.script_byte < OP_LEN8) begin
						role_d = ROLE_DIRECT;
						len_accum_d = {24'd0, in_ch.script_byte};
						pay_left_d = {24'd0, in_ch.script_byte};
						plen_d = {24'd0, in_ch.script_byte};
						phase_d = PH_PAYLOAD;
					end else begin
						role_d = ROLE_EXTENDED;
						len_left_d = length_field_size(in_ch.script_byte);
						len_accum_d = 32'd0;
						phase_d = PH_LENGTH;
					end
				end
			endcase
		end

		if (finish) begin
			phase_d = PH_WAIT;
			if (at_limit) begin
				error_d = ST_TOO_MANY;
			end else begin
				chunks_d = chunks_q + COUNT_WIDTH'(1);
				done_d = 1'b1;
			end
		end

		if (in_ch.last_byte && error_d == ST_OK && phase_d != PH_WAIT) begin
			error_d = ST_TRUNCATED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			opcode_q <= 8'd0;
			len_left_q <= 3'd0;
			len_accum_q <= 32'd0;
			pay_left_q <= 32'd0;
			chunks_q <= '0;
			error_q <= ST_OK;
			out_valid_q <= 1'b0;
			role_q <= ROLE_PLAIN;
			op_q <= 8'd0;
			data_q <= 8'd0;
			plen_q <= 32'd0;
			done_q <= 1'b0;
			count_q <= 16'd0;
			last_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (in_ch.ready) begin
				out_valid_q <= in_ch.valid;
			end
			if (accept) begin
				role_q <= role_d;
				op_q <= op_d;
				data_q <= data_d;
				plen_q <= plen_d;
				done_q <= done_d;
				count_q <= 16'(chunks_d);
				last_q <= in_ch.last_byte;
				status_q <= error_d;
				if (in_ch.last_byte) begin
					phase_q <= PH_WAIT;
					opcode_q <= 8'd0;
					len_left_q <= 3'd0;
					len_accum_q <= 32'd0;
					pay_left_q <= 32'd0;
					chunks_q <= '0;
					error_q <= ST_OK;
				end else begin
					phase_q <= phase_d;
					opcode_q <= opcode_d;
					len_left_q <= len_left_d;
					len_accum_q <= len_accum_d;
					pay_left_q <= pay_left_d;
					chunks_q <= chunks_d;
					error_q <= error_d;
				end
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.byte_role = role_q;
	assign out_ch.chunk_opcode = op_q;
	assign out_ch.data_byte = data_q;
	assign out_ch.payload_length = plen_q;
	assign out_ch.chunk_done = done_q;
	assign out_ch.chunk_count = count_q;
	assign out_ch.script_done = last_q;
	assign out_ch.status = status_q;

endmodule
`default_nettype wire

>>> rtl/scp_checker.sv
// Checker: port-level properties of the script chunk parser and its bind
`default_nettype none
module scp_checker
	import scp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [2:0] byte_role,
	input wire logic [7:0] data_byte,
	input wire logic [31:0] payload_length,
	input wire logic chunk_done,
	input wire logic [1:0] status
);

	a_ignored_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_IGNORED |-> status != ST_OK)
		else $error("ignored byte reported without an error status");

	a_done_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chunk_done |-> status == ST_OK && byte_role != ROLE_IGNORED)
		else $error("chunk completed while an error is set");

	a_data_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role != ROLE_PAYLOAD |-> data_byte == 8'd0)
		else $error("data byte nonzero outside payload");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_length) &&
		$stable(byte_role))
		else $error("stalled transaction changed");

endmodule

bind script_chunk_parser scp_checker u_scp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.byte_role(out_ch.byte_role),
	.data_byte(out_ch.data_byte),
	.payload_length(out_ch.payload_length),
	.chunk_done(out_ch.chunk_done),
	.status(out_ch.status)
);
`default_nettype wire
